@@ rtl/bcpd_pkg.sv @@
// Shared types, constants and the microcode table of the cascaded PD/PI balance controller.
// Depends on nothing; the top level imports it.
package bcpd_pkg;

    // Field and datapath widths.
    localparam int ANGLE_W       = 17;
    localparam int RATE_W        = 16;
    localparam int COUNT_W       = 16;
    localparam int DRIVE_W       = 16;
    localparam int GAIN_W        = 32;
    localparam int LIMIT_W       = 15;
    localparam int FE_W          = 18;
    localparam int SI_W          = 16;
    localparam int SI_SUM_W      = 19;
    localparam int ERR_W         = 17;
    localparam int FILT_SUM_W    = 22;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int ACC_W         = PROD_W;
    localparam int SAT_W         = 32;
    localparam int PC_W          = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 32;

    localparam int GAIN_FRAC_BITS_DEF = 20;
    localparam int ANGLE_FRAC_BITS    = 8;

    // floor(n / 10) == (n * DIV10_MAGIC) >> DIV10_SHIFT for every n below 2^32.
    localparam logic signed [MUL_W-1:0] DIV10_MAGIC = 33'sh0_CCCC_CCCD;
    localparam int DIV10_SHIFT = 35;

    // Register reset values.
    localparam logic [ANGLE_W-1:0] BALANCE_ANGLE_RST  = 17'd768;
    localparam logic [GAIN_W-1:0]  UPRIGHT_KP_RST     = 32'd127087821;
    localparam logic [GAIN_W-1:0]  UPRIGHT_KD_RST     = 32'd251658;
    localparam logic [GAIN_W-1:0]  SPEED_KP_RST       = 32'hFFFE_8F5C;
    localparam logic [GAIN_W-1:0]  SPEED_KI_RST       = 32'hFFFF_FE28;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 15'd20000;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST    = 15'd7200;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_ANGLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_KI       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT    = 3'd6;

    // Microprogram step addresses.
    localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] S_MUL_PD   = 4'd1;
    localparam logic [PC_W-1:0] S_MUL_D    = 4'd2;
    localparam logic [PC_W-1:0] S_MUL_DIV  = 4'd3;
    localparam logic [PC_W-1:0] S_UPRIGHT  = 4'd4;
    localparam logic [PC_W-1:0] S_INTEG    = 4'd5;
    localparam logic [PC_W-1:0] S_MUL_I    = 4'd6;
    localparam logic [PC_W-1:0] S_ADD_I    = 4'd7;
    localparam logic [PC_W-1:0] S_SPEED    = 4'd8;
    localparam logic [PC_W-1:0] S_MUL_VS   = 4'd9;
    localparam logic [PC_W-1:0] S_COMBINE  = 4'd10;
    localparam logic [PC_W-1:0] S_OUT      = 4'd11;

    typedef enum logic [2:0] {
        MA_KP, MA_KD, MA_SKP, MA_SKI, MA_MAGIC
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_DIFF, MB_RATE, MB_NMAG, MB_FE, MB_SI, MB_VS
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_VU_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        GO_ALWAYS, GO_IN, GO_OUT_FREE
    } go_cond_t;

    // One control word. The step advances when its go condition holds,
    // to target when jmp is set and to the next address otherwise.
    typedef struct packed {
        mul_a_sel_t      mul_a;
        mul_b_sel_t      mul_b;
        acc_op_t         acc_op;
        logic            wr_vu;
        logic            wr_fe;
        logic            wr_si;
        logic            wr_vs;
        logic            wr_out;
        go_cond_t        go;
        logic            jmp;
        logic [PC_W-1:0] target;
    } ctrl_t;

    localparam ctrl_t UC_NOP = '{
        mul_a: MA_KP, mul_b: MB_DIFF, acc_op: ACC_HOLD,
        wr_vu: 1'b0, wr_fe: 1'b0, wr_si: 1'b0, wr_vs: 1'b0, wr_out: 1'b0,
        go: GO_ALWAYS, jmp: 1'b0, target: S_IDLE
    };

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = UC_NOP;
        unique case (pc)
            S_IDLE: begin
                w.go = GO_IN;
            end
            S_MUL_PD: begin
                w.mul_a = MA_KP;
                w.mul_b = MB_DIFF;
            end
            S_MUL_D: begin
                w.mul_a  = MA_KD;
                w.mul_b  = MB_RATE;
                w.acc_op = ACC_LOAD;
            end
            S_MUL_DIV: begin
                w.mul_a  = MA_MAGIC;
                w.mul_b  = MB_NMAG;
                w.acc_op = ACC_ADD;
            end
            S_UPRIGHT: begin
                w.wr_vu = 1'b1;
                w.wr_fe = 1'b1;
            end
            S_INTEG: begin
                w.wr_si = 1'b1;
                w.mul_a = MA_SKP;
                w.mul_b = MB_FE;
            end
            S_MUL_I: begin
                w.mul_a  = MA_SKI;
                w.mul_b  = MB_SI;
                w.acc_op = ACC_LOAD;
            end
            S_ADD_I: begin
                w.acc_op = ACC_ADD;
            end
            S_SPEED: begin
                w.wr_vs = 1'b1;
            end
            S_MUL_VS: begin
                w.mul_a = MA_KP;
                w.mul_b = MB_VS;
            end
            S_COMBINE: begin
                w.acc_op = ACC_VU_SUB;
            end
            S_OUT: begin
                w.wr_out = 1'b1;
                w.go     = GO_OUT_FREE;
                w.jmp    = 1'b1;
                w.target = S_IDLE;
            end
            default: begin
                w.jmp    = 1'b1;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/balance_cascade_pd_pi_controller_top.sv @@
// The sequencer runs each accepted sample through the microprogram to the output step, which
// holds until the output register is free; an 11-step microprogram runs every product
// through a single 33x33 multiplier, so no new sample is taken until the program is done.
// A sample is accepted only in the idle step; a result may wait in the output register.
// Reset (aresetn low, synchronous) loads register defaults, clears filter and integral
// state, and returns the sequencer to idle with no result pending.
module balance_cascade_pd_pi_controller_top
    import bcpd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Fields from bit 0 up: pitch_angle[16:0], pitch_rate[32:17], left_count[48:33],
    // right_count[64:49], zero fill.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Fields from bit 0 up: left_drive[15:0], right_drive[31:16].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] MIN32 = ACC_W'(-64'sd2147483648);

    // Configuration registers.
    logic signed [ANGLE_W-1:0] ba_reg;
    logic signed [GAIN_W-1:0]  kp_reg;
    logic signed [GAIN_W-1:0]  kd_reg;
    logic signed [GAIN_W-1:0]  skp_reg;
    logic signed [GAIN_W-1:0]  ski_reg;
    logic [LIMIT_W-1:0]        il_reg;
    logic [LIMIT_W-1:0]        dl_reg;

    // Latched sample.
    logic signed [ANGLE_W-1:0] angle_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [COUNT_W-1:0] left_reg;
    logic signed [COUNT_W-1:0] right_reg;

    // Loop state and datapath registers.
    logic signed [FE_W-1:0]    fe_reg;
    logic signed [SI_W-1:0]    si_reg;
    logic signed [SAT_W-1:0]   vu_reg;
    logic signed [SAT_W-1:0]   vs_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [PC_W-1:0]           pc_reg;
    logic                      m_tvalid_reg;
    logic [DRIVE_W-1:0]        drive_reg;

    ctrl_t                     uc;
    logic                      in_acc;
    logic                      out_free;
    logic                      go;
    logic [PC_W-1:0]           pc_next;

    logic signed [ANGLE_W:0]     diff;
    logic signed [ERR_W-1:0]     err;
    logic signed [FILT_SUM_W-1:0] err_x;
    logic signed [FILT_SUM_W-1:0] fe_x;
    logic signed [FILT_SUM_W-1:0] filt_sum;
    logic                        filt_neg;
    logic [FILT_SUM_W-1:0]       filt_mag;
    logic [FE_W-1:0]             quot;
    logic signed [FE_W-1:0]      fe_next;
    logic signed [SI_SUM_W-1:0]  si_sum;
    logic signed [SI_SUM_W-1:0]  si_lim;
    logic signed [SI_W-1:0]      si_next;
    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     tq_vu;
    logic signed [ACC_W-1:0]     tq_f;
    logic signed [ACC_W-1:0]     drive_lim;
    logic [DRIVE_W-1:0]          drive_next;

    // Division by 2^sh that rounds toward zero.
    function automatic logic signed [ACC_W-1:0] trunc_shr(
        input logic signed [ACC_W-1:0] a,
        input int                      sh
    );
        logic [ACC_W-1:0]        bias;
        logic signed [ACC_W-1:0] biased;
        bias   = a[ACC_W-1] ? ((ACC_W'(1) << sh) - ACC_W'(1)) : '0;
        biased = a + bias;
        return biased >>> sh;
    endfunction

    function automatic logic signed [SAT_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
        logic signed [SAT_W-1:0] r;
        if (a > MAX32) begin
            r = MAX32[SAT_W-1:0];
        end else if (a < MIN32) begin
            r = MIN32[SAT_W-1:0];
        end else begin
            r = a[SAT_W-1:0];
        end
        return r;
    endfunction

    assign uc        = ucode_rom(pc_reg);
    assign s_tready  = (pc_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {drive_reg, drive_reg};

    always_comb begin
        unique case (uc.go)
            GO_ALWAYS:   go = 1'b1;
            GO_IN:       go = in_acc;
            GO_OUT_FREE: go = out_free;
            default:     go = 1'b1;
        endcase
        if (!go) begin
            pc_next = pc_reg;
        end else if (uc.jmp) begin
            pc_next = uc.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    // Upright error and the low-pass filter numerator 3*err + 7*filtered_error.
    assign diff     = {angle_reg[ANGLE_W-1], angle_reg} - {ba_reg[ANGLE_W-1], ba_reg};
    assign err      = {left_reg[COUNT_W-1], left_reg} - {right_reg[COUNT_W-1], right_reg};
    assign err_x    = FILT_SUM_W'(err);
    assign fe_x     = FILT_SUM_W'(fe_reg);
    assign filt_sum = err_x + (err_x <<< 1) + (fe_x <<< 3) - fe_x;
    assign filt_neg = filt_sum[FILT_SUM_W-1];
    assign filt_mag = filt_neg ? FILT_SUM_W'(-filt_sum) : FILT_SUM_W'(filt_sum);

    // The quotient of the magnitude by ten comes back from the multiplier.
    assign quot    = prod_reg[DIV10_SHIFT +: FE_W];
    assign fe_next = filt_neg ? -$signed(quot) : $signed(quot);

    assign si_sum = SI_SUM_W'(si_reg) + SI_SUM_W'(fe_reg);
    assign si_lim = $signed(SI_SUM_W'(il_reg));
    always_comb begin
        if (si_sum > si_lim) begin
            si_next = si_lim[SI_W-1:0];
        end else if (si_sum < -si_lim) begin
            si_next = SI_W'(-si_lim);
        end else begin
            si_next = si_sum[SI_W-1:0];
        end
    end

    always_comb begin
        unique case (uc.mul_a)
            MA_KP:    mul_a = MUL_W'(kp_reg);
            MA_KD:    mul_a = MUL_W'(kd_reg);
            MA_SKP:   mul_a = MUL_W'(skp_reg);
            MA_SKI:   mul_a = MUL_W'(ski_reg);
            MA_MAGIC: mul_a = DIV10_MAGIC;
            default:  mul_a = MUL_W'(kp_reg);
        endcase
        unique case (uc.mul_b)
            MB_DIFF: mul_b = MUL_W'(diff);
            MB_RATE: mul_b = MUL_W'($signed({rate_reg, {ANGLE_FRAC_BITS{1'b0}}}));
            MB_NMAG: mul_b = $signed(MUL_W'(filt_mag));
            MB_FE:   mul_b = MUL_W'(fe_reg);
            MB_SI:   mul_b = MUL_W'(si_reg);
            MB_VS:   mul_b = MUL_W'(vs_reg);
            default: mul_b = MUL_W'(diff);
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        unique case (uc.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_LOAD:   acc_next = prod_reg;
            ACC_ADD:    acc_next = acc_reg + prod_reg;
            ACC_VU_SUB: acc_next = (ACC_W'(vu_reg) <<< GAIN_FRAC_BITS) - prod_reg;
            default:    acc_next = acc_reg;
        endcase
    end

    assign tq_vu     = trunc_shr(acc_reg, GAIN_FRAC_BITS + ANGLE_FRAC_BITS);
    assign tq_f      = trunc_shr(acc_reg, GAIN_FRAC_BITS);
    assign drive_lim = $signed(ACC_W'(dl_reg));

    always_comb begin
        if (tq_f > drive_lim) begin
            drive_next = drive_lim[DRIVE_W-1:0];
        end else if (tq_f < -drive_lim) begin
            drive_next = DRIVE_W'(-drive_lim);
        end else begin
            drive_next = tq_f[DRIVE_W-1:0];
        end
    end

    // Control state, configuration and loop state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            ba_reg       <= BALANCE_ANGLE_RST;
            kp_reg       <= UPRIGHT_KP_RST;
            kd_reg       <= UPRIGHT_KD_RST;
            skp_reg      <= SPEED_KP_RST;
            ski_reg      <= SPEED_KI_RST;
            il_reg       <= INTEGRAL_LIMIT_RST;
            dl_reg       <= DRIVE_LIMIT_RST;
            fe_reg       <= '0;
            si_reg       <= '0;
        end else begin
            pc_reg <= pc_next;
            if (uc.wr_out && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_BALANCE_ANGLE:  ba_reg  <= cfg_data[ANGLE_W-1:0];
                    CFG_UPRIGHT_KP:     kp_reg  <= cfg_data;
                    CFG_UPRIGHT_KD:     kd_reg  <= cfg_data;
                    CFG_SPEED_KP:       skp_reg <= cfg_data;
                    CFG_SPEED_KI:       ski_reg <= cfg_data;
                    CFG_INTEGRAL_LIMIT: il_reg  <= cfg_data[LIMIT_W-1:0];
                    CFG_DRIVE_LIMIT:    dl_reg  <= cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (uc.wr_fe) begin
                fe_reg <= fe_next;
            end
            if (uc.wr_si) begin
                si_reg <= si_next;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            angle_reg <= s_tdata[ANGLE_W-1:0];
            rate_reg  <= s_tdata[ANGLE_W +: RATE_W];
            left_reg  <= s_tdata[ANGLE_W + RATE_W +: COUNT_W];
            right_reg <= s_tdata[ANGLE_W + RATE_W + COUNT_W +: COUNT_W];
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (uc.wr_vu) begin
            vu_reg <= sat32(tq_vu);
        end
        if (uc.wr_vs) begin
            vs_reg <= sat32(tq_f);
        end
        if (uc.wr_out && out_free) begin
            drive_reg <= drive_next;
        end
    end

    // A new result can only come from the output step of the program.
    a_out_from_last_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(pc_reg) == S_OUT)
        else $error("result appeared outside the output step");

    // An accepted sample starts the program at its first arithmetic step.
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> pc_reg == S_MUL_PD)
        else $error("sequencer did not start after an accepted sample");

    // The integral update always lands inside the configured bound.
    a_integral_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(pc_reg) == S_INTEG && $past(aresetn))
            |-> ($signed({1'b0, si_reg[SI_W-1] ? -si_reg : si_reg})
                 <= $signed({1'b0, $past(il_reg)})))
        else $error("speed integral outside its limit");

    // Both motors carry the same drive.
    a_equal_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DRIVE_W-1:0] == m_tdata[M_TDATA_W-1:DRIVE_W])
        else $error("left and right drive differ");

endmodule
